// ----- rtl/vertex_transform_4x4_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the vertex transform
// Concurrent assertion shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_4X4_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_ASSERT_SVH

// Same-cycle implication.
`define VT4_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex transform assertion failed");

// Next-cycle implication.
`define VT4_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex transform assertion failed");

`endif

// ----- rtl/vt4_pkg.sv -----
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared constants, operation codes and lane control type.
// ----------------------------------------------------------------------------
package vt4_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int DIM       = 4;
    localparam int MAT_ELEMS = DIM * DIM;
    localparam int IDX_BITS  = $clog2(MAT_ELEMS);

    typedef enum logic
    {
        OP_LOAD      = 1'b0,
        OP_TRANSFORM = 1'b1
    } op_t;

    typedef struct packed
    {
        logic pp_en;
        logic prod_en;
        logic pair_en;
    } lane_ctrl_t;

endpackage

// ----- rtl/vt4_in_if.sv -----
// ----------------------------------------------------------------------------
// Vertex input channel
// Valid/ready channel carrying matrix loads and vectors to transform.
// ----------------------------------------------------------------------------
interface vt4_in_if #(parameter int WORD_BITS = vt4_pkg::WORD_BITS);

    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [vt4_pkg::IDX_BITS-1:0]       element_index;
    logic signed [WORD_BITS-1:0]        element_value;
    logic signed [WORD_BITS-1:0]        vec_x;
    logic signed [WORD_BITS-1:0]        vec_y;
    logic signed [WORD_BITS-1:0]        vec_z;
    logic signed [WORD_BITS-1:0]        vec_w;

    modport source
    (
        output valid, operation, element_index, element_value,
        output vec_x, vec_y, vec_z, vec_w,
        input  ready
    );

    modport sink
    (
        input  valid, operation, element_index, element_value,
        input  vec_x, vec_y, vec_z, vec_w,
        output ready
    );

endinterface

// ----- rtl/vt4_out_if.sv -----
// ----------------------------------------------------------------------------
// Transformed vertex output channel
// Valid/ready channel carrying the four saturated components and overflow.
// ----------------------------------------------------------------------------
interface vt4_out_if #(parameter int WORD_BITS = vt4_pkg::WORD_BITS);

    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] out_x;
    logic signed [WORD_BITS-1:0] out_y;
    logic signed [WORD_BITS-1:0] out_z;
    logic signed [WORD_BITS-1:0] out_w;
    logic                        overflow;

    modport source
    (
        output valid, out_x, out_y, out_z, out_w, overflow,
        input  ready
    );

    modport sink
    (
        input  valid, out_x, out_y, out_z, out_w, overflow,
        output ready
    );

endinterface

// ----- rtl/vt4_lane.sv -----
// ----------------------------------------------------------------------------
// Row dot product lane
// Three-stage pipeline computing one matrix row times the vector, then a
// combinational round, shift and saturate of the registered pair sums.
// ----------------------------------------------------------------------------
module vt4_lane #(
    parameter int WORD_BITS = vt4_pkg::WORD_BITS,
    parameter int FRAC_BITS = vt4_pkg::FRAC_BITS
) (
    input  logic                        clk,
    input  vt4_pkg::lane_ctrl_t         ctrl,
    input  logic signed [WORD_BITS-1:0] row [vt4_pkg::DIM],
    input  logic signed [WORD_BITS-1:0] vec [vt4_pkg::DIM],
    output logic signed [WORD_BITS-1:0] value,
    output logic                        sat
);

    localparam int HALF = WORD_BITS / 2;
    localparam int PL   = WORD_BITS + HALF + 1;
    localparam int PH   = 2 * WORD_BITS - HALF;
    localparam int PW   = 2 * WORD_BITS;
    localparam int SW   = PW + 2;
    localparam logic signed [SW-1:0] ROUND = SW'(1) << (FRAC_BITS - 1);

    logic signed [PL-1:0] pp_lo_reg  [vt4_pkg::DIM];
    logic signed [PL-1:0] pp_lo_next [vt4_pkg::DIM];
    logic signed [PH-1:0] pp_hi_reg  [vt4_pkg::DIM];
    logic signed [PH-1:0] pp_hi_next [vt4_pkg::DIM];
    logic signed [PW-1:0] prod_reg   [vt4_pkg::DIM];
    logic signed [PW-1:0] prod_next  [vt4_pkg::DIM];
    logic signed [PW:0]   pair_reg   [2];
    logic signed [PW:0]   pair_next  [2];
    logic signed [SW-1:0] total;
    logic signed [SW-1:0] shifted;

    // The vector is split into an unsigned low half and a signed high half.
    always_comb
    begin
        logic signed [HALF:0]             vlo;
        logic signed [WORD_BITS-HALF-1:0] vhi;
        for (int c = 0; c < vt4_pkg::DIM; c++)
        begin
            vlo = $signed({1'b0, vec[c][HALF-1:0]});
            vhi = $signed(vec[c][WORD_BITS-1:HALF]);
            pp_lo_next[c] = row[c] * vlo;
            pp_hi_next[c] = row[c] * vhi;
        end
    end

    always_comb
    begin
        for (int c = 0; c < vt4_pkg::DIM; c++)
        begin
            prod_next[c] = $signed({pp_hi_reg[c], {HALF{1'b0}}})
                         + $signed({{(PW-PL){pp_lo_reg[c][PL-1]}}, pp_lo_reg[c]});
        end
        pair_next[0] = $signed({prod_reg[0][PW-1], prod_reg[0]})
                     + $signed({prod_reg[1][PW-1], prod_reg[1]});
        pair_next[1] = $signed({prod_reg[2][PW-1], prod_reg[2]})
                     + $signed({prod_reg[3][PW-1], prod_reg[3]});
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pp_en)
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
        end
        if (ctrl.prod_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.pair_en)
        begin
            pair_reg <= pair_next;
        end
    end

    always_comb
    begin
        total   = $signed({pair_reg[0][PW], pair_reg[0]})
                + $signed({pair_reg[1][PW], pair_reg[1]}) + ROUND;
        shifted = total >>> FRAC_BITS;
        sat     = !((&shifted[SW-1:WORD_BITS-1]) || !(|shifted[SW-1:WORD_BITS-1]));
        if (!sat)
        begin
            value = shifted[WORD_BITS-1:0];
        end
        else if (shifted[SW-1])
        begin
            value = $signed({1'b1, {(WORD_BITS-1){1'b0}}});
        end
        else
        begin
            value = $signed({1'b0, {(WORD_BITS-1){1'b1}}});
        end
    end

endmodule

// ----- rtl/vt4_merge.sv -----
// ----------------------------------------------------------------------------
// Lane merge and output register
// Collects the four lane results, combines their overflow flags and holds
// the result until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module vt4_merge #(
    parameter int WORD_BITS = vt4_pkg::WORD_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [WORD_BITS-1:0] lane_value [vt4_pkg::DIM],
    input  logic                        lane_sat   [vt4_pkg::DIM],
    vt4_out_if.source                   result
);

    logic                        valid_reg;
    logic                        valid_next;
    logic signed [WORD_BITS-1:0] x_reg;
    logic signed [WORD_BITS-1:0] y_reg;
    logic signed [WORD_BITS-1:0] z_reg;
    logic signed [WORD_BITS-1:0] w_reg;
    logic                        ovf_reg;
    logic                        load;

    assign in_ready   = !valid_reg || result.ready;
    assign load       = in_valid && in_ready;
    assign valid_next = load || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg   <= lane_value[0];
            y_reg   <= lane_value[1];
            z_reg   <= lane_value[2];
            w_reg   <= lane_value[3];
            ovf_reg <= lane_sat[0] | lane_sat[1] | lane_sat[2] | lane_sat[3];
        end
    end

    assign result.valid    = valid_reg;
    assign result.out_x    = x_reg;
    assign result.out_y    = y_reg;
    assign result.out_z    = z_reg;
    assign result.out_w    = w_reg;
    assign result.overflow = ovf_reg;

endmodule

// ----- rtl/vertex_transform_4x4.sv -----
// ----------------------------------------------------------------------------
// Homogeneous 4x4 vertex transform
// Signed fixed-point matrix times vector with rounding and saturation.
// ----------------------------------------------------------------------------
// Items arrive on the vertex channel and transfer when valid and ready are
// both high. A load item writes one matrix element, row-major, and yields no
// result. A transform item yields one result on the result channel: the four
// row dot products, each rounded to nearest and saturated, plus an overflow
// flag that is set when any component saturated.
// One item is accepted per clock unless a stalled receiver has filled the
// pipeline. A transform passes through a vector register, a partial product
// stage, a product stage and a pair sum stage in each of four row lanes, then
// the merge register that drives the result channel. The rate is set by the
// single partial product pass per lane, which has one multiplier pair per
// column.
// A load may follow or precede a transform back to back; each transform sees
// exactly the loads that came before it.
// Reset puts the identity matrix in place and empties the pipeline.
// When the receiver stalls, each stage holds while the one after it is full,
// so the block keeps accepting items until all five stages are occupied.
// ----------------------------------------------------------------------------
module vertex_transform_4x4 #(
    parameter int WORD_BITS = vt4_pkg::WORD_BITS,
    parameter int FRAC_BITS = vt4_pkg::FRAC_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    vt4_in_if.sink    vertex,
    vt4_out_if.source result
);

    localparam logic signed [WORD_BITS-1:0] ONE =
        {{(WORD_BITS-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic signed [WORD_BITS-1:0] matrix_reg [vt4_pkg::MAT_ELEMS];
    logic signed [WORD_BITS-1:0] lane_row   [vt4_pkg::DIM][vt4_pkg::DIM];
    logic signed [WORD_BITS-1:0] vec_reg    [vt4_pkg::DIM];
    logic signed [WORD_BITS-1:0] lane_value [vt4_pkg::DIM];
    logic                        lane_sat   [vt4_pkg::DIM];

    logic vec_valid_reg,  vec_valid_next;
    logic pp_valid_reg,   pp_valid_next;
    logic prod_valid_reg, prod_valid_next;
    logic pair_valid_reg, pair_valid_next;

    logic take_vec, take_pp, take_prod, take_pair;
    logic load_vec, load_pp, load_prod, load_pair;
    logic merge_ready;
    logic write_elem;

    vt4_pkg::lane_ctrl_t lane_ctrl;

    always_comb
    begin
        take_pair = !pair_valid_reg || merge_ready;
        load_pair = prod_valid_reg && take_pair;
        take_prod = !prod_valid_reg || take_pair;
        load_prod = pp_valid_reg && take_prod;
        take_pp   = !pp_valid_reg || take_prod;
        load_pp   = vec_valid_reg && take_pp;
        take_vec  = !vec_valid_reg || take_pp;

        load_vec   = vertex.valid && take_vec
                   && (vertex.operation == vt4_pkg::OP_TRANSFORM);
        write_elem = vertex.valid && take_vec
                   && (vertex.operation == vt4_pkg::OP_LOAD);

        vec_valid_next  = load_vec  || (vec_valid_reg  && !take_pp);
        pp_valid_next   = load_pp   || (pp_valid_reg   && !take_prod);
        prod_valid_next = load_prod || (prod_valid_reg && !take_pair);
        pair_valid_next = load_pair || (pair_valid_reg && !merge_ready);

        lane_ctrl.pp_en   = load_pp;
        lane_ctrl.prod_en = load_prod;
        lane_ctrl.pair_en = load_pair;
    end

    assign vertex.ready = take_vec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_valid_reg  <= 1'b0;
            pp_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            pair_valid_reg <= 1'b0;
        end
        else
        begin
            vec_valid_reg  <= vec_valid_next;
            pp_valid_reg   <= pp_valid_next;
            prod_valid_reg <= prod_valid_next;
            pair_valid_reg <= pair_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vt4_pkg::MAT_ELEMS; i++)
            begin
                matrix_reg[i] <= ((i / vt4_pkg::DIM) == (i % vt4_pkg::DIM)) ? ONE : '0;
            end
        end
        else if (write_elem)
        begin
            matrix_reg[vertex.element_index] <= vertex.element_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_vec)
        begin
            vec_reg[0] <= vertex.vec_x;
            vec_reg[1] <= vertex.vec_y;
            vec_reg[2] <= vertex.vec_z;
            vec_reg[3] <= vertex.vec_w;
        end
    end

    always_comb
    begin
        for (int r = 0; r < vt4_pkg::DIM; r++)
        begin
            for (int c = 0; c < vt4_pkg::DIM; c++)
            begin
                lane_row[r][c] = matrix_reg[r * vt4_pkg::DIM + c];
            end
        end
    end

    for (genvar r = 0; r < vt4_pkg::DIM; r++)
    begin : g_lane
        vt4_lane #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .ctrl  (lane_ctrl),
            .row   (lane_row[r]),
            .vec   (vec_reg),
            .value (lane_value[r]),
            .sat   (lane_sat[r])
        );
    end

    vt4_merge #(
        .WORD_BITS (WORD_BITS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pair_valid_reg),
        .in_ready   (merge_ready),
        .lane_value (lane_value),
        .lane_sat   (lane_sat),
        .result     (result)
    );

endmodule

// ----- rtl/vt4_checker.sv -----
// ----------------------------------------------------------------------------
// Vertex transform port checker
// Watches the top-level channels for latency, backpressure and saturation.
// ----------------------------------------------------------------------------
`include "vertex_transform_4x4_assert.svh"

module vt4_checker #(
    parameter int WORD_BITS = vt4_pkg::WORD_BITS
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        in_op,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic signed [WORD_BITS-1:0] out_x,
    input logic signed [WORD_BITS-1:0] out_y,
    input logic signed [WORD_BITS-1:0] out_z,
    input logic signed [WORD_BITS-1:0] out_w,
    input logic                        overflow
);

    localparam logic signed [WORD_BITS-1:0] MAX_V = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] MIN_V = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic acc_transform;
    logic any_extreme;

    assign acc_transform = in_valid && in_ready && (in_op == vt4_pkg::OP_TRANSFORM);
    assign any_extreme   = (out_x == MAX_V) || (out_x == MIN_V)
                        || (out_y == MAX_V) || (out_y == MIN_V)
                        || (out_z == MAX_V) || (out_z == MIN_V)
                        || (out_w == MAX_V) || (out_w == MIN_V);

    // A transform with the receiver ready throughout reaches the output after the vector, lane and merge registers.
    `VT4_ASSERT_NEXT(a_latency, acc_transform ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)

    // A ready receiver leaves the pipeline free to take an item.
    `VT4_ASSERT_SAME(a_ready_flow, out_ready, in_ready)

    // A saturated result carries at least one clamped component.
    `VT4_ASSERT_SAME(a_ovf_extreme, out_valid && overflow, any_extreme)

    // A stalled result stays offered.
    `VT4_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

bind vertex_transform_4x4 vt4_checker #(
    .WORD_BITS (WORD_BITS)
) u_vt4_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vertex.valid),
    .in_ready  (vertex.ready),
    .in_op     (vertex.operation),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_x     (result.out_x),
    .out_y     (result.out_y),
    .out_z     (result.out_z),
    .out_w     (result.out_w),
    .overflow  (result.overflow)
);

// ----- tb/vertex_transform_4x4_tb.sv -----
// ----------------------------------------------------------------------------
// Vertex transform testbench
// Sends matrix loads and vectors to the 4x4 transform. The sender works in
// bursts, and the receiver stalls and holds off for long stretches. Every
// transformed vertex is checked either against the result typed into its
// table row or against a predictor that keeps its own copy of the matrix.
// A short table of directed rows covers reset, extremes, saturation and
// rounding ties. Random scenes of matrix loads and vectors follow.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_tb;

    typedef logic signed [vt4_pkg::WORD_BITS-1:0] word_t;

    typedef struct packed
    {
        word_t x;
        word_t y;
        word_t z;
        word_t w;
        logic  overflow;
    } xformed_t;

    typedef struct packed
    {
        vt4_pkg::op_t                 operation;
        logic [vt4_pkg::IDX_BITS-1:0] element_index;
        word_t                        element_value;
        word_t                        vec_x;
        word_t                        vec_y;
        word_t                        vec_z;
        word_t                        vec_w;
        logic                         typed;
        xformed_t                     typed_result;
    } vertex_item_t;

    localparam word_t    W_ZERO    = '0;
    localparam word_t    W_ONE     = word_t'(1) <<< vt4_pkg::FRAC_BITS;
    localparam word_t    W_TIE     = word_t'(1) <<< (vt4_pkg::FRAC_BITS - 1);
    localparam word_t    W_MAX     = {1'b0, {(vt4_pkg::WORD_BITS - 1){1'b1}}};
    localparam word_t    W_MIN     = {1'b1, {(vt4_pkg::WORD_BITS - 1){1'b0}}};
    localparam xformed_t NO_RESULT = '0;

    localparam int RANDOM_ITEMS = 900;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int DRAIN_TAIL   = 20;
    localparam int DIRECTED_N   = 19;

    localparam vertex_item_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{vt4_pkg::OP_TRANSFORM, 4'd0, W_ZERO, W_ONE, 2 * W_ONE, -3 * W_ONE, W_ONE,
          1'b1, '{W_ONE, 2 * W_ONE, -3 * W_ONE, W_ONE, 1'b0}},
        '{vt4_pkg::OP_TRANSFORM, 4'd0, W_ZERO, W_MAX, W_MIN, W_ZERO, -1,
          1'b1, '{W_MAX, W_MIN, W_ZERO, -1, 1'b0}},
        '{vt4_pkg::OP_LOAD, 4'd0, W_MAX, W_ZERO, W_ZERO, W_ZERO, W_ZERO,
          1'b0, NO_RESULT},
        '{vt4_pkg::OP_TRANSFORM, 4'd0, W_ZERO, W_MAX, W_ZERO, W_ZERO, W_ZERO,
          1'b1, '{W_MAX, W_ZERO, W_ZERO, W_ZERO, 1'b1}},
        '{vt4_pkg::OP_TRANSFORM, 4'd0, W_ZERO, W_MIN, W_ZERO, W_ZERO, W_ZERO,
          1'b1, '{W_MIN, W_ZERO, W_ZERO, W_ZERO, 1'b1}},
        '{vt4_pkg::OP_LOAD, 4'd0, W_MIN, W_ZERO, W_ZERO, W_ZERO, W_ZERO,
          1'b0, NO_RESULT},
        '{vt4_pkg::OP_TRANSFORM, 4'd0, W_ZERO, W_MIN, W_ZERO, W_ZERO, W_ZERO,
          1'b1, '{W_MAX, W_ZERO, W_ZERO, W_ZERO, 1'b1}},
        '{vt4_pkg::OP_LOAD, 4'd15, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO,
          1'b0, NO_RESULT},
        '{vt4_pkg::OP_TRANSFORM, 4'd0, W_ZERO, W_ONE, W_ONE, W_ONE, W_ONE,
          1'b0, NO_RESULT},
        '{vt4_pkg::OP_LOAD, 4'd5, 1, W_ZERO, W_ZERO, W_ZERO, W_ZERO,
          1'b0, NO_RESULT},
        '{vt4_pkg::OP_TRANSFORM, 4'd0, W_ZERO, W_ZERO, W_TIE, W_ZERO, W_ZERO,
          1'b1, '{W_ZERO, 1, W_ZERO, W_ZERO, 1'b0}},
        '{vt4_pkg::OP_TRANSFORM, 4'd0, W_ZERO, W_ZERO, -W_TIE, W_ZERO, W_ZERO,
          1'b1, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO, 1'b0}},
        '{vt4_pkg::OP_TRANSFORM, 4'd0, W_ZERO, W_ZERO, W_TIE - 1, W_ZERO, W_ZERO,
          1'b1, '{W_ZERO, W_ZERO, W_ZERO, W_ZERO, 1'b0}},
        '{vt4_pkg::OP_TRANSFORM, 4'd0, W_ZERO, W_ZERO, -W_TIE - 1, W_ZERO, W_ZERO,
          1'b1, '{W_ZERO, -1, W_ZERO, W_ZERO, 1'b0}},
        '{vt4_pkg::OP_LOAD, 4'd10, W_MAX, W_ZERO, W_ZERO, W_ZERO, W_ZERO,
          1'b0, NO_RESULT},
        '{vt4_pkg::OP_LOAD, 4'd3, W_MIN, W_ZERO, W_ZERO, W_ZERO, W_ZERO,
          1'b0, NO_RESULT},
        '{vt4_pkg::OP_TRANSFORM, 4'd0, W_ZERO, W_MAX, W_MAX, W_MAX, W_MAX,
          1'b0, NO_RESULT},
        '{vt4_pkg::OP_TRANSFORM, 4'd15, 32'h5a5a_a5a5, W_MIN, W_MIN, W_MIN, W_MIN,
          1'b0, NO_RESULT},
        '{vt4_pkg::OP_LOAD, 4'd12, W_ONE, W_MAX, W_MAX, W_MAX, W_MAX,
          1'b0, NO_RESULT}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    vt4_in_if  vertex_ch ();
    vt4_out_if result_ch ();

    word_t        shadow_matrix [vt4_pkg::MAT_ELEMS];
    vertex_item_t vertex_stream [$];
    xformed_t     awaited_vertices [$];
    int           error_count  = 0;
    int           vertices_out = 0;

    vertex_transform_4x4 DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vertex_ch),
        .result (result_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic xformed_t transform_vertex(input vertex_item_t item);
        word_t                                  vec [vt4_pkg::DIM];
        word_t                                  comp [vt4_pkg::DIM];
        logic signed [2*vt4_pkg::WORD_BITS+3:0] acc;
        logic signed [2*vt4_pkg::WORD_BITS+3:0] top;
        logic signed [2*vt4_pkg::WORD_BITS+3:0] bottom;
        logic                                   sat;
        int                                     r;
        int                                     c;
        vec[0] = item.vec_x;
        vec[1] = item.vec_y;
        vec[2] = item.vec_z;
        vec[3] = item.vec_w;
        top    = '0;
        top[vt4_pkg::WORD_BITS-2:0] = '1;
        bottom = '1;
        bottom[vt4_pkg::WORD_BITS-2:0] = '0;
        sat    = 1'b0;
        for (r = 0; r < vt4_pkg::DIM; r++)
        begin
            acc = '0;
            for (c = 0; c < vt4_pkg::DIM; c++)
                acc = acc + shadow_matrix[r * vt4_pkg::DIM + c] * vec[c];
            acc = (acc + (2 ** (vt4_pkg::FRAC_BITS - 1))) >>> vt4_pkg::FRAC_BITS;
            if (acc > top)
            begin
                comp[r] = W_MAX;
                sat     = 1'b1;
            end
            else if (acc < bottom)
            begin
                comp[r] = W_MIN;
                sat     = 1'b1;
            end
            else
                comp[r] = acc[vt4_pkg::WORD_BITS-1:0];
        end
        return '{comp[0], comp[1], comp[2], comp[3], sat};
    endfunction

    function automatic int unsigned pick_spread();
        case ($urandom_range(0, 4))
            0:       return 16;
            1:       return 1 << 17;
            2:       return 1 << 20;
            3:       return 1 << 24;
            default: return 0;
        endcase
    endfunction

    function automatic word_t rand_word(input int unsigned spread);
        int unsigned pick;
        pick = $urandom_range(0, 39);
        if (pick == 0)
        begin
            case ($urandom_range(0, 4))
                0:       return W_MAX;
                1:       return W_MIN;
                2:       return W_ZERO;
                3:       return W_ONE;
                default: return -W_ONE;
            endcase
        end
        if (pick < 3 || spread == 0)
            return word_t'($urandom);
        return word_t'(int'($urandom_range(0, 2 * spread)) - int'(spread));
    endfunction

    function automatic vertex_item_t load_item(input int unsigned index, input word_t value);
        vertex_item_t item;
        item.operation     = vt4_pkg::OP_LOAD;
        item.element_index = index[vt4_pkg::IDX_BITS-1:0];
        item.element_value = value;
        item.vec_x         = word_t'($urandom);
        item.vec_y         = word_t'($urandom);
        item.vec_z         = word_t'($urandom);
        item.vec_w         = word_t'($urandom);
        item.typed         = 1'b0;
        item.typed_result  = NO_RESULT;
        return item;
    endfunction

    function automatic vertex_item_t vector_item(input int unsigned spread);
        vertex_item_t item;
        item.operation     = vt4_pkg::OP_TRANSFORM;
        item.element_index = vt4_pkg::IDX_BITS'($urandom);
        item.element_value = word_t'($urandom);
        item.vec_x         = rand_word(spread);
        item.vec_y         = rand_word(spread);
        item.vec_z         = rand_word(spread);
        item.vec_w         = rand_word(spread);
        item.typed         = 1'b0;
        item.typed_result  = NO_RESULT;
        return item;
    endfunction

    function automatic void add_scene();
        int unsigned mat_spread;
        int unsigned vec_spread;
        int unsigned kind;
        int unsigned count;
        int unsigned start;
        int unsigned e;
        mat_spread = pick_spread();
        vec_spread = pick_spread();
        kind       = $urandom_range(0, 9);
        start      = $urandom_range(0, vt4_pkg::MAT_ELEMS - 1);
        if (kind < 4)
        begin
            for (e = 0; e < vt4_pkg::MAT_ELEMS; e++)
                vertex_stream.push_back(load_item((e + start) % vt4_pkg::MAT_ELEMS,
                                                  rand_word(mat_spread)));
        end
        else if (kind < 8)
        begin
            count = $urandom_range(1, 4);
            repeat (count)
                vertex_stream.push_back(load_item($urandom_range(0, vt4_pkg::MAT_ELEMS - 1),
                                                  rand_word(mat_spread)));
        end
        count = $urandom_range(2, 24);
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
                vertex_stream.push_back(load_item($urandom_range(0, vt4_pkg::MAT_ELEMS - 1),
                                                  rand_word(mat_spread)));
            else
                vertex_stream.push_back(vector_item(vec_spread));
        end
    endfunction

    task automatic note_error(input string what, input xformed_t want, input xformed_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s: expected %h %h %h %h ovf %b, got %h %h %h %h ovf %b", what,
                     want.x, want.y, want.z, want.w, want.overflow,
                     got.x, got.y, got.z, got.w, got.overflow);
    endtask

    always @(posedge clk)
    begin
        xformed_t got;
        xformed_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            vertices_out++;
            got = '{result_ch.out_x, result_ch.out_y, result_ch.out_z, result_ch.out_w,
                    result_ch.overflow};
            if (awaited_vertices.size() == 0)
                note_error("unexpected transfer", NO_RESULT, got);
            else
            begin
                want = awaited_vertices.pop_front();
                if (got !== want)
                    note_error("mismatch", want, got);
            end
        end
    end

    initial
    begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int          holds_done;
        mode_left  = 0;
        hold_left  = 0;
        holds_done = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (rst_n && holds_done < 2 && vertices_out >= 100 + holds_done * 250)
            begin
                holds_done++;
                hold_left = 60;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    default: result_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        vertex_item_t item;
        int           accepted;
        int           gap_left;
        int           burst_left;
        int           waited;
        int           i;
        vertex_ch.valid         <= 1'b0;
        vertex_ch.operation     <= vt4_pkg::OP_LOAD;
        vertex_ch.element_index <= '0;
        vertex_ch.element_value <= '0;
        vertex_ch.vec_x         <= '0;
        vertex_ch.vec_y         <= '0;
        vertex_ch.vec_z         <= '0;
        vertex_ch.vec_w         <= '0;
        for (i = 0; i < vt4_pkg::MAT_ELEMS; i++)
            shadow_matrix[i] = (i % (vt4_pkg::DIM + 1) == 0) ? W_ONE : W_ZERO;
        for (i = 0; i < DIRECTED_N; i++)
            vertex_stream.push_back(DIRECTED_ROWS[i]);
        while (vertex_stream.size() < DIRECTED_N + RANDOM_ITEMS)
            add_scene();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        accepted   = 0;
        gap_left   = 0;
        burst_left = $urandom_range(1, 12);
        while (accepted < vertex_stream.size())
        begin
            @(posedge clk);
            if (vertex_ch.valid && vertex_ch.ready)
            begin
                item = vertex_stream[accepted];
                if (item.operation == vt4_pkg::OP_LOAD)
                    shadow_matrix[item.element_index] = item.element_value;
                else if (item.typed)
                    awaited_vertices.push_back(item.typed_result);
                else
                    awaited_vertices.push_back(transform_vertex(item));
                accepted++;
            end
            if (!(vertex_ch.valid && !vertex_ch.ready))
            begin
                if (accepted == vertex_stream.size())
                    vertex_ch.valid <= 1'b0;
                else if (gap_left > 0)
                begin
                    gap_left--;
                    vertex_ch.valid <= 1'b0;
                end
                else
                begin
                    item = vertex_stream[accepted];
                    vertex_ch.valid         <= 1'b1;
                    vertex_ch.operation     <= item.operation;
                    vertex_ch.element_index <= item.element_index;
                    vertex_ch.element_value <= item.element_value;
                    vertex_ch.vec_x         <= item.vec_x;
                    vertex_ch.vec_y         <= item.vec_y;
                    vertex_ch.vec_z         <= item.vec_z;
                    vertex_ch.vec_w         <= item.vec_w;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end

        waited = 0;
        while (awaited_vertices.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_TAIL) @(posedge clk);
        if (awaited_vertices.size() != 0)
        begin
            error_count += awaited_vertices.size();
            $display("%0d transformed vertices never arrived", awaited_vertices.size());
        end

        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
